/* hdl/pt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pt_pkg;

    localparam int PAGE_OFFSET_BITS = 12;
    localparam int TABLE_LEVELS     = 4;
    localparam int NUM_FRAMES       = 256;

    localparam int ENTRY_SIZE_LOG2  = 3;
    localparam int INDEX_BITS       = PAGE_OFFSET_BITS - ENTRY_SIZE_LOG2;
    localparam int FRAME_W          = $clog2(NUM_FRAMES);
    localparam int FREE_W           = $clog2(NUM_FRAMES + 1);
    localparam int ENTRY_W          = FRAME_W + 1;
    localparam int STORE_AW         = FRAME_W + INDEX_BITS;
    localparam int STORE_DEPTH      = NUM_FRAMES * (1 << INDEX_BITS);
    localparam int LVL_W            = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;
    localparam int VA_W             = 48;
    localparam int BASE_W           = 36;
    localparam int STATUS_W         = 2;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_ALLOCATE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_NOFRAME  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [ENTRY_W-1:0]  wdata;
    } t_store_req;

    // table index of one level; positions past the top of the word give zero
    function automatic logic [INDEX_BITS-1:0] level_index(
        input logic [VA_W-1:0]  va,
        input logic [LVL_W-1:0] lvl
    );
        logic [INDEX_BITS-1:0] idx;
        logic [63:0]           v;
        idx = '0;
        v   = 64'(va);
        for (int i = 0; i < TABLE_LEVELS; i++) begin
            if (lvl == LVL_W'(i)) begin
                idx = INDEX_BITS'(v >> (PAGE_OFFSET_BITS + (TABLE_LEVELS - 1 - i) * INDEX_BITS));
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* hdl/multilevel_page_table_walk.sv */
`timescale 1ns / 1ps
`default_nettype none

// Page table walker with its own entry store and bump frame allocator.
// Command channel: drive i_command and i_virtual_address with i_start; the
// word is taken at a clock edge where i_start is high and o_busy is low.
// Command 0 translates the address, command 1 allocates the root, any missing
// table levels and the data frame, then returns the translation.
// Result channel: o_done is high for exactly one cycle with o_phys_addr
// and o_status (0 ok, 1 unmapped, 2 out of frames); there is no back pressure.
// Walk: a walk that reaches the last level does one store read and one check
// or write step for each level on the single store port, then one step to
// form the address. A walk that stops early takes fewer steps. One command
// is in flight at a time and o_busy is low again in the o_done cycle.
// Configuration: i_cfg_we writes i_cfg_wdata to the frame base register.
// Reset: after i_rst_n the store is cleared one entry per cycle, all 131072
// entries at the default sizing, with o_busy high; the root and allocator start
// empty and the frame base is zero.
module multilevel_page_table_walk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic                          i_command,
    input  wire logic [pt_pkg::VA_W-1:0]       i_virtual_address,
    input  wire logic                          i_cfg_we,
    input  wire logic [pt_pkg::BASE_W-1:0]     i_cfg_wdata,
    output logic                               o_done,
    output logic [pt_pkg::VA_W-1:0]            o_phys_addr,
    output logic [pt_pkg::STATUS_W-1:0]        o_status
);

    logic [pt_pkg::BASE_W-1:0]  r_frame_base;
    pt_pkg::t_store_req         store_req;
    logic [pt_pkg::ENTRY_W-1:0] store_rdata;
    logic                       clearing;
    logic                       walk_idle;
    logic                       accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
        end else if (i_cfg_we) begin
            r_frame_base <= i_cfg_wdata;
        end
    end

    assign o_busy = clearing || !walk_idle;
    assign accept = i_start && !o_busy;

    pt_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rdata    (store_rdata),
        .o_clearing (clearing)
    );

    pt_walk u_walk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_command          (i_command),
        .i_virtual_address  (i_virtual_address),
        .i_frame_base       (r_frame_base),
        .i_rdata            (store_rdata),
        .o_req              (store_req),
        .o_idle             (walk_idle),
        .o_done             (o_done),
        .o_phys_addr        (o_phys_addr),
        .o_status           (o_status)
    );

endmodule

`default_nettype wire

/* hdl/pt_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module pt_store (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pt_pkg::t_store_req              i_req,
    output logic [pt_pkg::ENTRY_W-1:0]           o_rdata,
    output logic                                 o_clearing
);

    logic [pt_pkg::ENTRY_W-1:0]  r_mem [pt_pkg::STORE_DEPTH];
    logic [pt_pkg::ENTRY_W-1:0]  r_rdata;
    logic                        r_clearing;
    logic [pt_pkg::STORE_AW-1:0] r_clr_addr;

    // clearing pass: one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == pt_pkg::STORE_AW'(pt_pkg::STORE_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

/* hdl/pt_walk.sv */
`timescale 1ns / 1ps
`default_nettype none

module pt_walk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_command,
    input  wire logic [pt_pkg::VA_W-1:0]       i_virtual_address,
    input  wire logic [pt_pkg::BASE_W-1:0]     i_frame_base,
    input  wire logic [pt_pkg::ENTRY_W-1:0]    i_rdata,
    output pt_pkg::t_store_req                 o_req,
    output logic                               o_idle,
    output logic                               o_done,
    output logic [pt_pkg::VA_W-1:0]            o_phys_addr,
    output logic [pt_pkg::STATUS_W-1:0]        o_status
);

    pt_pkg::t_state                  r_state, n_state;
    logic                            r_cmd;
    logic [pt_pkg::VA_W-1:0]         r_va;
    logic [pt_pkg::LVL_W-1:0]        r_lvl;
    logic [pt_pkg::FRAME_W-1:0]      r_frame;
    logic [pt_pkg::FRAME_W-1:0]      r_root_frame;
    logic                            r_root_present;
    logic [pt_pkg::FREE_W-1:0]       r_next_free;
    logic [pt_pkg::STORE_AW-1:0]     r_addr;
    pt_pkg::t_status                 r_status;
    logic                            r_done;
    logic [pt_pkg::VA_W-1:0]         r_pa;

    logic                            no_free;
    logic                            entry_valid;
    logic                            last_lvl;
    logic [pt_pkg::FRAME_W-1:0]      free_frame;
    logic [pt_pkg::STORE_AW-1:0]     rd_addr;
    logic [pt_pkg::BASE_W:0]         pfn;
    logic [pt_pkg::VA_W-1:0]         formed_pa;
    logic                            do_alloc;

    assign no_free     = (r_next_free == pt_pkg::FREE_W'(pt_pkg::NUM_FRAMES));
    assign entry_valid = i_rdata[0];
    assign last_lvl    = (r_lvl == pt_pkg::LVL_W'(pt_pkg::TABLE_LEVELS - 1));
    assign free_frame  = r_next_free[pt_pkg::FRAME_W-1:0];
    assign rd_addr     = {r_frame, pt_pkg::level_index(r_va, r_lvl)};

    // address adder: frame base plus frame, then the page offset below it
    assign pfn       = {1'b0, i_frame_base} + (pt_pkg::BASE_W + 1)'(r_frame);
    assign formed_pa = pt_pkg::VA_W'({pfn, r_va[pt_pkg::PAGE_OFFSET_BITS-1:0]});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pt_pkg::S_IDLE: begin
                if (i_accept) begin
                    if (r_root_present) begin
                        n_state = pt_pkg::S_READ;
                    end else if (i_command == pt_pkg::CMD_ALLOCATE && !no_free) begin
                        n_state = pt_pkg::S_READ;
                    end else begin
                        n_state = pt_pkg::S_FINISH;
                    end
                end
            end
            pt_pkg::S_READ:  n_state = pt_pkg::S_CHECK;
            pt_pkg::S_CHECK: begin
                if (!entry_valid && (r_cmd == pt_pkg::CMD_TRANSLATE || no_free)) begin
                    n_state = pt_pkg::S_FINISH;
                end else if (last_lvl) begin
                    n_state = pt_pkg::S_FINISH;
                end else begin
                    n_state = pt_pkg::S_READ;
                end
            end
            pt_pkg::S_FINISH: n_state = pt_pkg::S_IDLE;
            default:  n_state = pt_pkg::S_IDLE;
        endcase
    end

    // store port and idle output
    always_comb begin
        do_alloc    = (r_state == pt_pkg::S_CHECK) && !entry_valid &&
                      (r_cmd == pt_pkg::CMD_ALLOCATE) && !no_free;
        o_req.we    = do_alloc;
        o_req.addr  = (r_state == pt_pkg::S_CHECK) ? r_addr : rd_addr;
        o_req.wdata = {free_frame, 1'b1};
        o_idle      = (r_state == pt_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= pt_pkg::S_IDLE;
            r_root_present <= 1'b0;
            r_root_frame   <= '0;
            r_next_free    <= '0;
            r_done         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == pt_pkg::S_FINISH);
            unique case (r_state)
                pt_pkg::S_IDLE: begin
                    if (i_accept) begin
                        r_cmd <= i_command;
                        r_va  <= i_virtual_address;
                        r_lvl <= '0;
                        if (r_root_present) begin
                            r_frame <= r_root_frame;
                        end else if (i_command == pt_pkg::CMD_TRANSLATE) begin
                            r_status <= pt_pkg::ST_UNMAPPED;
                        end else if (no_free) begin
                            r_status <= pt_pkg::ST_NOFRAME;
                        end else begin
                            r_root_frame   <= free_frame;
                            r_root_present <= 1'b1;
                            r_frame        <= free_frame;
                            r_next_free    <= r_next_free + 1'b1;
                        end
                    end
                end
                pt_pkg::S_READ: begin
                    r_addr <= rd_addr;
                end
                pt_pkg::S_CHECK: begin
                    r_status <= pt_pkg::ST_OK;
                    if (entry_valid) begin
                        r_frame <= i_rdata[pt_pkg::ENTRY_W-1:1];
                    end else if (r_cmd == pt_pkg::CMD_TRANSLATE) begin
                        r_status <= pt_pkg::ST_UNMAPPED;
                    end else if (no_free) begin
                        r_status <= pt_pkg::ST_NOFRAME;
                    end else begin
                        r_frame     <= free_frame;
                        r_next_free <= r_next_free + 1'b1;
                    end
                    r_lvl <= r_lvl + 1'b1;
                end
                pt_pkg::S_FINISH: begin
                    r_pa <= (r_status == pt_pkg::ST_OK) ? formed_pa : '0;
                end
                default: ;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_phys_addr = r_pa;
    assign o_status    = r_status;

endmodule

`default_nettype wire

/* hdl/pt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_start,
    input wire logic                          o_busy,
    input wire logic                          o_done,
    input wire logic [pt_pkg::VA_W-1:0]       o_phys_addr,
    input wire logic [pt_pkg::STATUS_W-1:0]   o_status
);

    // an accepted word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy low right after accept");

    // a result always follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result without a walk");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // failed walks return a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != pt_pkg::STATUS_W'(pt_pkg::ST_OK)) |->
        (o_phys_addr == '0))
        else $error("nonzero address on failed walk");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == pt_pkg::STATUS_W'(pt_pkg::ST_OK) ||
                    o_status == pt_pkg::STATUS_W'(pt_pkg::ST_UNMAPPED) ||
                    o_status == pt_pkg::STATUS_W'(pt_pkg::ST_NOFRAME)))
        else $error("undefined status code");

endmodule

bind multilevel_page_table_walk pt_checker u_pt_checker (.*);

`default_nettype wire
